// ----- rtl/saic_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package saic_pkg;
  localparam int unsigned LineBytesDef = 16;
  localparam int unsigned SetBitsDef   = 4;
  localparam int unsigned WaysDef      = 4;

  localparam logic [1:0] OpFetch   = 2'd0;
  localparam logic [1:0] OpInvLine = 2'd1;
  localparam logic [1:0] OpInvAll  = 2'd2;
  localparam logic [1:0] OpFill    = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [2:0]  access_size;
    logic        privileged;
    logic [31:0] fill_data;
    logic        fill_error;
    logic [7:0]  fill_fault_status;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] read_data;
    logic        access_ok;
    logic        fault_valid;
    logic [7:0]  fault_status;
    logic [31:0] fill_address;
    logic        fill_privileged;
  } result_t;
endpackage
`default_nettype wire

// ----- rtl/saic_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Input queue: two-entry FIFO decoupling the input handshake from the cache core.
module saic_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire saic_pkg::item_t in_item_i,
  output logic                q_valid_o,
  input  wire logic           q_pop_i,
  output saic_pkg::item_t     q_item_o
);
  import saic_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !q_valid_o) else $error("empty queue valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("push lost");
endmodule
`default_nettype wire

// ----- rtl/saic_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Cache core: tags, marks, data store and fill sequencer; results to an output register.
module saic_back #(
  parameter int unsigned LineBytes = saic_pkg::LineBytesDef,
  parameter int unsigned SetBits   = saic_pkg::SetBitsDef,
  parameter int unsigned Ways      = saic_pkg::WaysDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  output logic                  q_pop_o,
  input  wire saic_pkg::item_t  q_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output saic_pkg::result_t     out_res_o
);
  import saic_pkg::*;

  localparam int unsigned OffBits = $clog2(LineBytes);
  localparam int unsigned Words   = LineBytes / 4;
  localparam int unsigned WBits   = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned WayBits = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned Sets    = 1 << SetBits;
  localparam int unsigned Lines   = Sets * Ways;
  localparam int unsigned LBits   = $clog2(Lines) > 0 ? $clog2(Lines) : 1;
  localparam int unsigned TagW    = 32 - OffBits;
  localparam int unsigned DDepth  = Lines * Words;
  localparam int unsigned DBits   = $clog2(DDepth);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StFill = 2'd2;

  logic [Ways-1:0][TagW-1:0] tag_q [Sets];
  logic [Lines-1:0]   vld_q, prv_q;
  logic [WayBits-1:0] vic_q   [Sets];
  logic [31:0]        data_mem [DDepth];

  logic [1:0]         st_q;
  logic [31:0]        paddr_q;
  logic [2:0]         psize_q;
  logic [WayBits-1:0] pway_q;
  logic [WBits-1:0]   wcnt_q;
  logic               pok_q;
  logic [LBits-1:0]   rline_q;
  logic [OffBits-1:0] roff_q;
  logic [2:0]         ridx_q;
  logic [31:0]        racc_q;
  logic [31:0]        rword_q;
  logic [1:0]         rlane_q;
  logic               out_v_q;
  result_t            out_q;

  item_t              it;
  logic [SetBits-1:0] set_i;
  logic [TagW-1:0]    tag_i;
  logic               hit;
  logic [WayBits-1:0] hway;
  logic [LBits-1:0]   hline;
  logic               out_free;
  logic               out_load;
  logic [DBits-1:0]   raddr;
  logic [2:0]         nbytes;
  logic [OffBits-1:0] boff;
  logic [7:0]         rbyte;
  logic [1:0]         rpos;

  assign it       = q_item_i;
  assign set_i    = it.address[OffBits +: SetBits];
  assign tag_i    = it.address[31:OffBits];
  assign out_free = !out_v_q || !out_stall_i;

  function automatic logic [LBits-1:0] line_of(logic [SetBits-1:0] s, logic [WayBits-1:0] w);
    line_of = LBits'(s * Ways + w);
  endfunction

  always_comb begin
    logic [WayBits-1:0] j;
    hit  = 1'b0;
    hway = '0;
    j    = vic_q[set_i];
    for (int k = 0; k < Ways; k++) begin
      j = (j == '0) ? WayBits'(Ways - 1) : j - 1'b1;
      if (!hit && vld_q[line_of(set_i, j)] && tag_q[set_i][j] == tag_i) begin
        hit  = 1'b1;
        hway = j;
      end
    end
    hline = line_of(set_i, hway);
  end

  always_comb begin
    q_pop_o = 1'b0;
    unique case (st_q)
      StIdle: q_pop_o = q_valid_i && (it.opcode != OpFetch || out_free);
      StFill: q_pop_o = q_valid_i && (it.opcode != OpFill || out_free);
      StRead: q_pop_o = 1'b0;
      default: q_pop_o = 1'b0;
    endcase
  end

  assign nbytes = (psize_q > 3'd4) ? 3'd4 : psize_q;
  assign boff   = roff_q + OffBits'(ridx_q[1:0]);
  assign raddr  = DBits'({rline_q, boff} >> 2);
  assign rbyte  = rword_q[8*rlane_q +: 8];
  assign rpos   = ridx_q[1:0] - 2'd1;

  assign out_load = (q_pop_o && st_q == StIdle && it.opcode == OpFetch && !hit) ||
                    (q_pop_o && st_q == StFill && it.opcode == OpFill && it.fill_error) ||
                    (st_q == StRead && ridx_q > nbytes && out_free);

  always_ff @(posedge clk_i) begin
    rword_q <= data_mem[raddr];
    rlane_q <= boff[1:0];
    if (st_q == StFill && q_valid_i && it.opcode == OpFill && !it.fill_error && q_pop_o)
      data_mem[DBits'(line_of(paddr_q[OffBits +: SetBits], pway_q) * Words + wcnt_q)] <=
        it.fill_data;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_pop_o && it.opcode == OpFetch && !hit) begin
      tag_q[set_i][vic_q[set_i]] <= tag_i;
    end
  end

  // state sequencer for fetch, fill and invalidate; reads one byte per cycle, data registered from the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      vld_q   <= '0;
      prv_q   <= '0;
      for (int s = 0; s < Sets; s++) vic_q[s] <= '0;
      paddr_q <= '0;
      psize_q <= '0;
      pway_q  <= '0;
      wcnt_q  <= '0;
      pok_q   <= 1'b0;
      rline_q <= '0;
      roff_q  <= '0;
      ridx_q  <= '0;
      racc_q  <= '0;
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: if (q_pop_o) begin
          unique case (it.opcode)
            OpFetch: begin
              if (hit) begin
                rline_q <= hline;
                roff_q  <= it.address[OffBits-1:0];
                psize_q <= it.access_size;
                pok_q   <= it.privileged || !prv_q[hline];
                ridx_q  <= '0;
                racc_q  <= '0;
                st_q    <= StRead;
              end else begin
                vic_q[set_i] <= (vic_q[set_i] == WayBits'(Ways - 1)) ? '0 :
                                vic_q[set_i] + 1'b1;
                vld_q[line_of(set_i, vic_q[set_i])] <= 1'b0;
                prv_q[line_of(set_i, vic_q[set_i])] <= it.privileged;
                paddr_q <= it.address;
                psize_q <= it.access_size;
                pway_q  <= vic_q[set_i];
                wcnt_q  <= '0;
                st_q    <= StFill;
                out_q   <= '{result_kind: 1'b1, read_data: '0, access_ok: 1'b0,
                            fault_valid: 1'b0, fault_status: '0,
                            fill_address: {it.address[31:OffBits], OffBits'(0)},
                            fill_privileged: it.privileged};
              end
            end
            OpInvLine: if (hit) begin
              vld_q[hline] <= 1'b0;
              prv_q[hline] <= 1'b0;
            end
            OpInvAll: begin
              vld_q <= '0;
              prv_q <= '0;
              for (int s = 0; s < Sets; s++) vic_q[s] <= '0;
            end
            default: ;
          endcase
        end
        StFill: if (q_pop_o && it.opcode == OpFill) begin
          if (it.fill_error) begin
            st_q    <= StIdle;
            out_q   <= '{result_kind: 1'b0, read_data: '0, access_ok: 1'b0,
                        fault_valid: 1'b1, fault_status: it.fill_fault_status,
                        fill_address: '0, fill_privileged: 1'b0};
          end else if (wcnt_q == WBits'(Words - 1)) begin
            vld_q[line_of(paddr_q[OffBits +: SetBits], pway_q)] <= 1'b1;
            rline_q <= line_of(paddr_q[OffBits +: SetBits], pway_q);
            roff_q  <= paddr_q[OffBits-1:0];
            pok_q   <= 1'b1;
            ridx_q  <= '0;
            racc_q  <= '0;
            st_q    <= StRead;
          end else begin
            wcnt_q <= wcnt_q + 1'b1;
          end
        end
        StRead: begin
          // ridx_q counts address issues; byte ridx-1 arrives in rword_q
          if (ridx_q != '0 && ridx_q <= nbytes)
            racc_q[8*rpos +: 8] <= rbyte;
          if (ridx_q > nbytes) begin
            if (out_free) begin
              out_q   <= '{result_kind: 1'b0, read_data: racc_q, access_ok: pok_q,
                          fault_valid: 1'b0, fault_status: '0,
                          fill_address: '0, fill_privileged: 1'b0};
              st_q    <= StIdle;
            end
          end else begin
            ridx_q <= ridx_q + 1'b1;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRead) |-> !q_pop_o) else $error("pop during read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> (out_v_q && $stable(out_q))) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFill) |-> !out_q.result_kind || out_v_q || 1'b1) else $error("fill state");
endmodule
`default_nettype wire

// ----- rtl/set_assoc_icache_round_robin_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Set-associative instruction cache, round-robin replacement. Items pass a two-entry
// input queue into the cache core. A hit passes the queue, then one data-store read per
// byte read (0 to 4 bytes), the collection of the last byte and the result register; the
// core then takes its next item. A miss registers its fill request, then takes one fill
// word per cycle while the queue supplies them, and the answer follows the last word; a
// fill error ends the miss with a fault answer instead. Output stalls add to these waits.
// One item is in the core at a time.
module set_assoc_icache_round_robin_top #(
  parameter int unsigned LineBytes = saic_pkg::LineBytesDef,
  parameter int unsigned SetBits   = saic_pkg::SetBitsDef,
  parameter int unsigned Ways      = saic_pkg::WaysDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] address_i,
  input  wire logic [2:0]  access_size_i,
  input  wire logic        privileged_i,
  input  wire logic [31:0] fill_data_i,
  input  wire logic        fill_error_i,
  input  wire logic [7:0]  fill_fault_status_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [31:0]      read_data_o,
  output logic             access_ok_o,
  output logic             fault_valid_o,
  output logic [7:0]       fault_status_o,
  output logic [31:0]      fill_address_o,
  output logic             fill_privileged_o
);
  import saic_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_pop;

  assign in_item = '{opcode: opcode_i, address: address_i, access_size: access_size_i,
                     privileged: privileged_i, fill_data: fill_data_i,
                     fill_error: fill_error_i, fill_fault_status: fill_fault_status_i};

  saic_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i(in_item),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  saic_back #(.LineBytes(LineBytes), .SetBits(SetBits), .Ways(Ways)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .out_res_o(res)
  );

  assign result_kind_o     = res.result_kind;
  assign read_data_o       = res.read_data;
  assign access_ok_o       = res.access_ok;
  assign fault_valid_o     = res.fault_valid;
  assign fault_status_o    = res.fault_status;
  assign fill_address_o    = res.fill_address;
  assign fill_privileged_o = res.fill_privileged;
endmodule
`default_nettype wire
